// ===== design/srr_pkg.sv =====
// Shared constants, types and state codes for the sorted run ranker.
package srr_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 10;
	localparam int ORD_W = 11;
	localparam int QNT_W = 32;
	localparam int KEY_W = 64;
	localparam int MODE_W = 3;
	localparam int REM_W = CNT_W + 2;
	localparam int QCNT_W = $clog2(QNT_W);
	localparam int WORD_W = 1 + CNT_W + IDX_W + POS_W;

	localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QNT_W - 1);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MIN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MAX = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DENSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUANT = 3'd4;

	typedef struct packed {
		logic cmd;
		logic [POS_W-1:0] source_position;
		logic [KEY_W-1:0] key;
		logic is_null;
		logic last_item;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] ranked_position;
		logic [ORD_W-1:0] ordinal_rank;
		logic [QNT_W-1:0] quant_frac;
		logic last_result;
	} out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic capture;
		logic div_step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic drain_ok;
		logic quant;
		logic div_done;
	} stat_t;

endpackage

// ===== design/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/srr_ctrl.sv =====
// Controller state machine sequencing loads, drain reads and the quantile divider.
module srr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic cmd,
	input srr_pkg::stat_t stat,
	output srr_pkg::ctrl_t ctrl,
	output logic busy
);
	import srr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && cmd == CMD_DRAIN && stat.drain_ok) state_d = S_READ;
			end
			S_READ: begin
				state_d = stat.quant ? S_DIV : S_FIN;
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				ctrl.load = start && cmd == CMD_LOAD;
				ctrl.rd = start && cmd == CMD_DRAIN && stat.drain_ok;
			end
			S_READ: begin
				ctrl.capture = 1'b1;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
			end
			S_FIN: begin
				ctrl.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end
endmodule

// ===== design/srr_dp.sv =====
// Datapath: load bookkeeping, element store, rank selection and radix-2 divider.
module srr_dp (
	input logic clk,
	input logic arst_n,
	input srr_pkg::in_t request,
	input logic cfg_we,
	input logic [srr_pkg::MODE_W-1:0] cfg_wdata,
	input srr_pkg::ctrl_t ctrl,
	output srr_pkg::stat_t stat,
	output srr_pkg::out_t result,
	output logic result_valid
);
	import srr_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0] prev_key_q;
	logic prev_null_q;
	logic [CNT_W-1:0] loaded_q, dense_q, drain_idx_q;
	logic [IDX_W-1:0] open_rs_q, cre_q;
	logic drain_active_q, strobe_q;
	logic [POS_W-1:0] pos_q;
	logic [IDX_W-1:0] rs_q;
	logic [CNT_W-1:0] dr_q;
	logic tie_q;
	logic [REM_W-1:0] rem_q;
	logic [QNT_W-1:0] quo_q;
	logic [QCNT_W-1:0] cnt_q;
	out_t result_q;

	logic [WORD_W-1:0] wdata, rdata;
	logic room, marks, same, tie, we;
	logic [IDX_W-1:0] widx, ors_new;
	logic [CNT_W-1:0] dense_new, count_new, fin_i;
	logic [REM_W-1:0] den, shifted;
	logic [ORD_W-1:0] ord;

	assign room = loaded_q < CNT_W'(CAPACITY);
	assign widx = loaded_q[IDX_W-1:0];
	assign marks = mode_q >= MODE_MIN && mode_q <= MODE_QUANT;
	assign same = request.is_null ? prev_null_q
		: (!prev_null_q && request.key == prev_key_q);
	assign tie = marks && loaded_q != '0 && same;
	assign dense_new = tie ? dense_q : dense_q + CNT_W'(1);
	assign ors_new = tie ? open_rs_q : widx;
	assign we = ctrl.load && !drain_active_q && room;
	assign count_new = room ? loaded_q + CNT_W'(1) : loaded_q;
	assign wdata = {tie, dense_new, ors_new, request.source_position};

	srr_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(widx),
		.wdata(wdata),
		.re(ctrl.rd),
		.raddr(IDX_W'(drain_idx_q - CNT_W'(1))),
		.rdata(rdata)
	);

	assign den = REM_W'({loaded_q, 1'b0});
	assign shifted = {rem_q[REM_W-2:0], 1'b0};
	assign fin_i = drain_idx_q - CNT_W'(1);

	always_comb begin
		case (mode_q)
			MODE_MIN: ord = ORD_W'(rs_q) + ORD_W'(1);
			MODE_MAX: ord = ORD_W'(cre_q) + ORD_W'(1);
			MODE_DENSE: ord = ORD_W'(dr_q);
			MODE_QUANT: ord = '0;
			default: ord = ORD_W'(fin_i) + ORD_W'(1);
		endcase
	end

	assign stat.drain_ok = drain_active_q && drain_idx_q != '0;
	assign stat.quant = mode_q == MODE_QUANT;
	assign stat.div_done = cnt_q == QCNT_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIRST;
			prev_key_q <= '0;
			prev_null_q <= 1'b0;
			loaded_q <= '0;
			dense_q <= '0;
			open_rs_q <= '0;
			drain_idx_q <= '0;
			cre_q <= '0;
			drain_active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.finish;
			if (cfg_we) mode_q <= cfg_wdata;
			if (ctrl.load && !drain_active_q) begin
				if (room) begin
					dense_q <= dense_new;
					open_rs_q <= ors_new;
					prev_key_q <= request.key;
					prev_null_q <= request.is_null;
					loaded_q <= count_new;
				end
				if (request.last_item && count_new != '0) begin
					drain_active_q <= 1'b1;
					drain_idx_q <= count_new;
					cre_q <= IDX_W'(count_new - CNT_W'(1));
				end
			end
			if (ctrl.finish) begin
				drain_idx_q <= fin_i;
				if (fin_i == '0) begin
					drain_active_q <= 1'b0;
					cre_q <= '0;
					prev_key_q <= '0;
					prev_null_q <= 1'b0;
					loaded_q <= '0;
					dense_q <= '0;
					open_rs_q <= '0;
				end else if (!tie_q) begin
					cre_q <= IDX_W'(fin_i - CNT_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			{tie_q, dr_q, rs_q, pos_q} <= rdata;
			rem_q <= REM_W'(rdata[POS_W +: IDX_W]) + REM_W'(cre_q) + REM_W'(1);
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (ctrl.div_step) begin
			cnt_q <= cnt_q + QCNT_W'(1);
			if (shifted >= den) begin
				rem_q <= shifted - den;
				quo_q <= {quo_q[QNT_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[QNT_W-2:0], 1'b0};
			end
		end
		if (ctrl.finish) begin
			result_q.ranked_position <= pos_q;
			result_q.ordinal_rank <= ord;
			result_q.quant_frac <= stat.quant ? quo_q : '0;
			result_q.last_result <= fin_i == '0;
		end
	end

	assign result = result_q;
	assign result_valid = strobe_q;
endmodule

// ===== design/sorted_run_ranker.sv =====
// Top level of the sorted run ranker: controller, datapath and element store.
// A request is taken when start is high and busy is low. A load request
// (cmd low) is absorbed in its cycle of acceptance and yields no result;
// busy stays low, so loads may follow one per cycle. The final load, marked
// by last_item, switches the block to draining. A drain request reads the
// element store, then forms the rank: busy stays high through the read and
// finish states for the first, min, max and dense rules, and through read,
// divide and finish in quantile mode, where the 32 quotient bits come one
// per cycle from the radix-2 divider. The result appears on result with
// result_valid high for one cycle, in the cycle in which busy falls, so no
// new request is accepted while a drain is in progress. The receiver cannot
// stall, so every strobe must be taken. Loads while draining and drains
// while loading are accepted and dropped. The rank rule is written through
// cfg_we and cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. Reset clears the controller, the
// rule and the loading state; the store holds no valid bits and needs no pass.
module sorted_run_ranker (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input srr_pkg::in_t request,
	input logic cfg_we,
	input logic [srr_pkg::MODE_W-1:0] cfg_wdata,
	output srr_pkg::out_t result,
	output logic result_valid
);
	import srr_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	srr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(request.cmd),
		.stat(stat),
		.ctrl(ctrl),
		.busy(busy)
	);

	srr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.ctrl(ctrl),
		.stat(stat),
		.result(result),
		.result_valid(result_valid)
	);
endmodule

// ===== bench/tb_sorted_run_ranker.sv =====
// Testbench for the sorted run ranker: directed table, random data sets and a predictor.
module tb_sorted_run_ranker;
	import srr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PAUSE = 40;
	localparam int IN_W = $bits(in_t);

	typedef struct {
		bit is_cfg;
		logic [MODE_W-1:0] mode;
		in_t req;
		bit typed;
		out_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t request;
	logic cfg_we;
	logic [MODE_W-1:0] cfg_wdata;
	out_t result;
	logic result_valid;

	logic req_typed;
	out_t req_want;

	out_t pending_ranks[$];
	int mismatch_cnt;
	int fail_cnt;
	int idle_cnt;
	int send_idle_pct;
	int items_sent;

	logic [POS_W-1:0] pos_mem [CAPACITY];
	int run_start_mem [CAPACITY];
	int dense_mem [CAPACITY];
	bit tie_mem [CAPACITY];
	logic [KEY_W-1:0] prev_key;
	bit prev_null;
	int loaded;
	int dense_cnt;
	int run_open;
	int drain_idx;
	int run_end;
	bit draining;
	logic [MODE_W-1:0] rank_mode;

	row_t plan [26];

	sorted_run_ranker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result(result),
		.result_valid(result_valid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic rank_predict(input in_t r, output bit has, output out_t o);
		int i;
		bit same;
		bit tie;
		longint unsigned num;
		longint unsigned den;
		has = 1'b0;
		o = '0;
		if (r.cmd == CMD_LOAD) begin
			if (!draining) begin
				if (loaded < CAPACITY) begin
					same = r.is_null ? prev_null : (!prev_null && r.key == prev_key);
					tie = rank_mode >= MODE_MIN && rank_mode <= MODE_QUANT && loaded > 0 && same;
					if (!tie) begin
						dense_cnt++;
						run_open = loaded;
					end
					pos_mem[loaded] = r.source_position;
					run_start_mem[loaded] = run_open;
					dense_mem[loaded] = dense_cnt;
					tie_mem[loaded] = tie;
					prev_key = r.key;
					prev_null = r.is_null;
					loaded++;
				end
				if (r.last_item && loaded > 0) begin
					draining = 1'b1;
					drain_idx = loaded;
					run_end = loaded - 1;
				end
			end
		end else if (draining && drain_idx > 0) begin
			i = drain_idx - 1;
			has = 1'b1;
			o.ranked_position = pos_mem[i];
			o.last_result = (i == 0);
			case (rank_mode)
				MODE_MIN: o.ordinal_rank = ORD_W'(run_start_mem[i] + 1);
				MODE_MAX: o.ordinal_rank = ORD_W'(run_end + 1);
				MODE_DENSE: o.ordinal_rank = ORD_W'(dense_mem[i]);
				MODE_QUANT: begin
					num = longint'(run_start_mem[i] + run_end + 1) << 32;
					den = 2 * longint'(loaded);
					o.quant_frac = QNT_W'(num / den);
				end
				default: o.ordinal_rank = ORD_W'(i + 1);
			endcase
			if (!tie_mem[i])
				run_end = i - 1;
			drain_idx = i;
			if (i == 0) begin
				draining = 1'b0;
				run_end = 0;
				prev_key = '0;
				prev_null = 1'b0;
				loaded = 0;
				dense_cnt = 0;
				run_open = 0;
			end
		end
	endtask

	always @(posedge clk) begin
		bit has;
		out_t o;
		out_t e;
		if (arst_n) begin
			if (cfg_we)
				rank_mode = cfg_wdata;
			if (result_valid) begin
				if (pending_ranks.size() == 0) begin
					fail_cnt++;
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("Unexpected result: %p", result);
				end else begin
					e = pending_ranks.pop_front();
					if (result !== e) begin
						fail_cnt++;
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("Mismatch: pos %0d/%0d ord %0d/%0d quant %h/%h last %b/%b",
								e.ranked_position, result.ranked_position,
								e.ordinal_rank, result.ordinal_rank,
								e.quant_frac, result.quant_frac,
								e.last_result, result.last_result);
					end
				end
			end
			if (start && !busy) begin
				rank_predict(request, has, o);
				if (has)
					pending_ranks.push_back(req_typed ? req_want : o);
			end
			if ((start && !busy) || result_valid)
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send(input in_t r, input bit typed = 1'b0, input out_t want = '0);
		start <= 1'b1;
		request <= r;
		req_typed <= typed;
		req_want <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		start <= 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic row_t ld(input int pos, input logic [KEY_W-1:0] k, input bit nul,
		input bit last);
		row_t w;
		w = '{default: '0};
		w.req = '{cmd: CMD_LOAD, source_position: POS_W'(pos), key: k, is_null: nul,
			last_item: last};
		return w;
	endfunction

	function automatic row_t dr();
		row_t w;
		w = '{default: '0};
		w.req.cmd = CMD_DRAIN;
		return w;
	endfunction

	function automatic row_t drt(input int pos, input int ord, input bit last);
		row_t w;
		w = dr();
		w.typed = 1'b1;
		w.want = '{ranked_position: POS_W'(pos), ordinal_rank: ORD_W'(ord),
			quant_frac: '0, last_result: last};
		return w;
	endfunction

	function automatic row_t cfr(input logic [MODE_W-1:0] m);
		row_t w;
		w = '{default: '0};
		w.is_cfg = 1'b1;
		w.mode = m;
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k);
		case ($urandom_range(3))
			0: return k;
			1: return {$urandom, $urandom};
			2: return KEY_W'($urandom_range(3));
			default: return $urandom_range(1) ? {KEY_W{1'b1}} : (64'd1 << 63);
		endcase
	endfunction

	task automatic random_set(input int len);
		in_t r;
		logic [KEY_W-1:0] k;
		int n;
		k = '0;
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(15) == 0) begin
				r = IN_W'({$urandom, $urandom, $urandom});
				r.cmd = CMD_DRAIN;
				send(r);
			end
			k = next_key(k);
			r.cmd = CMD_LOAD;
			r.source_position = POS_W'($urandom_range(1023));
			r.key = k;
			r.is_null = ($urandom_range(5) == 0);
			r.last_item = (j == len - 1);
			send(r);
		end
		if ($urandom_range(5) == 0)
			set_mode(MODE_W'($urandom_range(7)));
		n = len > CAPACITY ? CAPACITY : len;
		for (int j = 0; j < n; j++) begin
			if ($urandom_range(15) == 0) begin
				r = IN_W'({$urandom, $urandom, $urandom});
				r.cmd = CMD_LOAD;
				send(r);
			end
			r = IN_W'({$urandom, $urandom, $urandom});
			r.cmd = CMD_DRAIN;
			send(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_FIRST;
		req_typed = 1'b0;
		req_want = '0;
		mismatch_cnt = 0;
		fail_cnt = 0;
		idle_cnt = 0;
		items_sent = 0;
		send_idle_pct = 18;
		prev_key = '0;
		prev_null = 1'b0;
		loaded = 0;
		dense_cnt = 0;
		run_open = 0;
		drain_idx = 0;
		run_end = 0;
		draining = 1'b0;
		rank_mode = MODE_FIRST;
		plan = '{
			dr(),
			ld(1023, {KEY_W{1'b1}}, 1'b0, 1'b0),
			ld(0, {KEY_W{1'b1}}, 1'b0, 1'b1),
			ld(5, '0, 1'b0, 1'b0),
			drt(0, 2, 1'b0),
			drt(1023, 1, 1'b1),
			cfr(MODE_QUANT),
			ld(5, '0, 1'b1, 1'b0),
			ld(6, '0, 1'b1, 1'b0),
			ld(7, '0, 1'b0, 1'b0),
			ld(8, '0, 1'b0, 1'b1),
			dr(), dr(), dr(), dr(),
			cfr(MODE_MIN),
			ld(1, 64'h8000_0000_0000_0000, 1'b0, 1'b0),
			ld(2, 64'h8000_0000_0000_0000, 1'b0, 1'b0),
			ld(3, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1),
			cfr(MODE_DENSE),
			dr(), dr(), dr(),
			cfr(MODE_MAX),
			ld(9, '0, 1'b0, 1'b1),
			dr()
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_mode(plan[i].mode);
			else
				send(plan[i].req, plan[i].typed, plan[i].want);
		end

		items_sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 18 : (ph == 1 ? 59 : 0);
			while (items_sent < 133 * (ph + 1)) begin
				set_mode(MODE_W'($urandom_range(7)));
				random_set($urandom_range(9) == 0 ? $urandom_range(40, 13) : $urandom_range(1, 12));
			end
		end

		start <= 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
		if (fail_cnt == 0 && pending_ranks.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/srr_pkg.sv
design/srr_ram.sv
design/srr_ctrl.sv
design/srr_dp.sv
design/sorted_run_ranker.sv
bench/tb_sorted_run_ranker.sv
